// ===== rtl/stream_find_replace_core_macros.svh =====
// Assertion macros for the stream find-and-replace core
`ifndef STREAM_FIND_REPLACE_CORE_MACROS_SVH
`define STREAM_FIND_REPLACE_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, off during rst
`define SFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off during rst
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sfr_pkg.sv =====
// Shared types and constants for the stream find-and-replace core
package sfr_pkg;

  localparam int BYTE_W      = 8;
  localparam int BURST_DEPTH = 8;
  localparam int BURST_CW    = 4;
  localparam int TEXT_W      = 64;
  localparam int LEN_W       = 4;

  localparam logic [1:0] CFG_PATTERN_BYTES     = 2'd0;
  localparam logic [1:0] CFG_PATTERN_LENGTH    = 2'd1;
  localparam logic [1:0] CFG_REPLACEMENT_BYTES = 2'd2;
  localparam logic [1:0] CFG_REPLACEMENT_LEN   = 2'd3;

  typedef struct packed {
    logic grow;
    logic shift;
  } win_ctl_t;

  typedef struct packed {
    logic load;
    logic shift;
  } out_ctl_t;

endpackage

// ===== rtl/sfr_win_cell.sv =====
// Window cell: one held byte, its post-push value and the pattern compare
module sfr_win_cell (
  input  logic                      clk,
  input  sfr_pkg::win_ctl_t         ctl,
  input  logic                      sel_new,
  input  logic [sfr_pkg::BYTE_W-1:0] char_new,
  input  logic [sfr_pkg::BYTE_W-1:0] nbr_post,
  input  logic [sfr_pkg::BYTE_W-1:0] pat_byte,
  input  logic                      active,
  output logic [sfr_pkg::BYTE_W-1:0] post,
  output logic                      eq
);

  logic [sfr_pkg::BYTE_W-1:0] held;

  assign post = sel_new ? char_new : held;
  assign eq   = !active || (post == pat_byte);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      held <= nbr_post;
    end else if (ctl.grow) begin
      held <= post;
    end
  end

endmodule

// ===== rtl/sfr_out_cell.sv =====
// Output cell: one byte of the pending result burst, drains toward cell 0
module sfr_out_cell (
  input  logic                      clk,
  input  sfr_pkg::out_ctl_t         ctl,
  input  logic [sfr_pkg::BYTE_W-1:0] load_byte,
  input  logic [sfr_pkg::BYTE_W-1:0] nbr_byte,
  output logic [sfr_pkg::BYTE_W-1:0] held
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      held <= load_byte;
    end else if (ctl.shift) begin
      held <= nbr_byte;
    end
  end

endmodule

// ===== rtl/stream_find_replace_core.sv =====
// Latency: the first result of an input transfer is offered on m_* the next cycle.
// Throughput: one byte per cycle while each byte yields at most one result and
// m_tready is high; a burst of n results (replacement or flush, n up to 8) drains
// via the output cells; input is taken again in the cycle its last result leaves.
// Reset (rst, synchronous): clears registers, window count and pending burst.
`include "stream_find_replace_core_macros.svh"

module stream_find_replace_core #(
  parameter int MAX_PATTERN = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] char_out
  output logic        m_tuser,   // [0] char_valid
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam int BW = sfr_pkg::BYTE_W;
  localparam int BD = sfr_pkg::BURST_DEPTH;
  localparam int NW = sfr_pkg::BURST_CW;

  logic [sfr_pkg::TEXT_W-1:0] pat_bytes;
  logic [sfr_pkg::TEXT_W-1:0] rep_bytes;
  logic [sfr_pkg::LEN_W-1:0]  pat_len;
  logic [sfr_pkg::LEN_W-1:0]  rep_len;

  logic [CW-1:0] count;
  logic [CW-1:0] plen;
  logic [NW-1:0] rlen;
  logic          full;
  logic          match;
  logic          in_acc;
  logic          out_acc;

  logic [NW-1:0] n;
  logic [NW-1:0] n_next;
  logic          dv;
  logic          dv_next;
  logic          blast;

  logic [MAX_PATTERN-1:0] eq;
  logic [BW-1:0]          post [MAX_PATTERN];
  logic [BW-1:0]          burst [BD];
  logic [BW-1:0]          load_byte [BD];

  sfr_pkg::win_ctl_t wctl;
  sfr_pkg::out_ctl_t octl;

  assign cfg_ready = 1'b1;
  assign plen = (pat_len > sfr_pkg::LEN_W'(MAX_PATTERN)) ? CW'(MAX_PATTERN) : CW'(pat_len);
  assign rlen = (rep_len > NW'(BD)) ? NW'(BD) : NW'(rep_len);

  assign s_tready = (n == '0) || ((n == NW'(1)) && m_tready);
  assign in_acc   = s_tvalid && s_tready;
  assign out_acc  = m_tvalid && m_tready;

  assign full  = (plen != '0) && (CW'(count + 1'b1) == plen);
  assign match = full && (&eq);

  assign wctl.shift = in_acc && full && !match && !s_tlast;
  assign wctl.grow  = in_acc && (plen != '0) && !full && !s_tlast;

  assign octl.load  = in_acc;
  assign octl.shift = out_acc && !in_acc;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_PATTERN; gi++) begin : g_win
      logic [BW-1:0] nbr;
      if (gi == MAX_PATTERN - 1) begin : g_end
        assign nbr = '0;
      end else begin : g_mid
        assign nbr = post[gi + 1];
      end
      sfr_win_cell u_cell (
        .clk      (clk),
        .ctl      (wctl),
        .sel_new  (count == CW'(gi)),
        .char_new (s_tdata),
        .nbr_post (nbr),
        .pat_byte (pat_bytes[BW*gi +: BW]),
        .active   (CW'(gi) < plen),
        .post     (post[gi]),
        .eq       (eq[gi])
      );
    end

    for (gi = 0; gi < BD; gi++) begin : g_out
      logic [BW-1:0] nbr;
      logic [BW-1:0] win_byte;
      if (gi == BD - 1) begin : g_end
        assign nbr = '0;
      end else begin : g_mid
        assign nbr = burst[gi + 1];
      end
      if (gi < MAX_PATTERN) begin : g_wb
        assign win_byte = post[gi];
      end else begin : g_nowb
        assign win_byte = '0;
      end
      assign load_byte[gi] = match ? rep_bytes[BW*gi +: BW] :
                             (plen == '0) ? s_tdata : win_byte;
      sfr_out_cell u_cell (
        .clk       (clk),
        .ctl       (octl),
        .load_byte (load_byte[gi]),
        .nbr_byte  (nbr),
        .held      (burst[gi])
      );
    end
  endgenerate

  always_comb begin
    dv_next = 1'b1;
    if (plen == '0) begin
      n_next = NW'(1);
    end else if (match) begin
      n_next = rlen;
      if (s_tlast && (rlen == '0)) begin
        n_next  = NW'(1);
        dv_next = 1'b0;
      end
    end else if (s_tlast) begin
      n_next = NW'(count) + NW'(1);
    end else if (full) begin
      n_next = NW'(1);
    end else begin
      n_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_bytes <= '0;
      rep_bytes <= '0;
      pat_len   <= '0;
      rep_len   <= '0;
      count     <= '0;
      n         <= '0;
      dv        <= 1'b1;
      blast     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sfr_pkg::CFG_PATTERN_BYTES:     pat_bytes <= cfg_data;
          sfr_pkg::CFG_PATTERN_LENGTH:    pat_len   <= cfg_data[sfr_pkg::LEN_W-1:0];
          sfr_pkg::CFG_REPLACEMENT_BYTES: rep_bytes <= cfg_data;
          sfr_pkg::CFG_REPLACEMENT_LEN:   rep_len   <= cfg_data[sfr_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
      if (cfg_valid && cfg_ready && (cfg_index == sfr_pkg::CFG_PATTERN_LENGTH)) begin
        count <= '0;
      end else if (in_acc && (plen != '0)) begin
        if (match || s_tlast) begin
          count <= '0;
        end else if (!full) begin
          count <= CW'(count + 1'b1);
        end
      end
      if (in_acc) begin
        n     <= n_next;
        dv    <= dv_next;
        blast <= s_tlast;
      end else if (out_acc) begin
        n <= n - NW'(1);
      end
    end
  end

  assign m_tvalid = (n != '0);
  assign m_tdata  = dv ? burst[0] : '0;
  assign m_tuser  = dv;
  assign m_tlast  = blast && (n == NW'(1));

  `SFR_ASSERT_NOW(a_burst_bound, 1'b1, n <= NW'(BD), "result burst exceeds its cell row")
  `SFR_ASSERT_NOW(a_window_bound, plen != '0, count < plen, "window count reached pattern length")
  `SFR_ASSERT_NOW(a_marker_last, m_tvalid && !m_tuser, m_tlast && (m_tdata == '0), "bare marker not final")
  `SFR_ASSERT_NEXT(a_burst_drain, out_acc && !in_acc && (n > NW'(1)), m_tvalid, "burst lost a byte")

endmodule
